/* rtl/core/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and level tables of the programmable sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

	// request codes of the input channel
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_OVERSAMPLE = 2'd0;
	localparam logic [1:0] CFG_TABLE_SEL  = 2'd1;
	localparam logic [1:0] CFG_MUTE_MASK  = 2'd2;

	// sound register numbers
	localparam logic [3:0] REG_NOISE_PER  = 4'd6;
	localparam logic [3:0] REG_MIXER      = 4'd7;
	localparam logic [3:0] REG_AMP_A      = 4'd8;
	localparam logic [3:0] REG_ENV_FINE   = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE = 4'd12;
	localparam logic [3:0] REG_SHAPE      = 4'd13;
	localparam logic [3:0] REG_PORT_A     = 4'd14;

	localparam int          OVS_W   = 5;
	localparam logic [4:0]  OVS_MAX = 5'd16;
	localparam logic [17:0] NOISE_TAPS = 18'h24000;

	// mixer control shared by all three channels
	typedef struct packed {
		logic       table_sel;
		logic [2:0] mute;
		logic [5:0] mixer;
	} psg_mix_ctl_t;

	// envelope control from the request decoder
	typedef struct packed {
		logic       tick;
		logic       restart;
		logic [3:0] shape;
	} psg_env_ctl_t;

	// 16-step level table, each step used for two envelope levels
	function automatic logic [15:0] lvl_ay(input logic [3:0] idx);
		logic [15:0] v;
		unique case (idx)
			4'd0:  v = 16'd0;
			4'd1:  v = 16'd836;
			4'd2:  v = 16'd1212;
			4'd3:  v = 16'd1773;
			4'd4:  v = 16'd2619;
			4'd5:  v = 16'd3875;
			4'd6:  v = 16'd5397;
			4'd7:  v = 16'd8823;
			4'd8:  v = 16'd10392;
			4'd9:  v = 16'd16706;
			4'd10: v = 16'd23339;
			4'd11: v = 16'd29292;
			4'd12: v = 16'd36969;
			4'd13: v = 16'd46421;
			4'd14: v = 16'd55195;
			default: v = 16'd65535;
		endcase
		return v;
	endfunction

	// 32-step level table
	function automatic logic [15:0] lvl_ym(input logic [4:0] idx);
		logic [15:0] v;
		unique case (idx)
			5'd0:  v = 16'h0000;
			5'd1:  v = 16'h0000;
			5'd2:  v = 16'h00F8;
			5'd3:  v = 16'h01C2;
			5'd4:  v = 16'h029E;
			5'd5:  v = 16'h033A;
			5'd6:  v = 16'h03F2;
			5'd7:  v = 16'h04D7;
			5'd8:  v = 16'h0610;
			5'd9:  v = 16'h077F;
			5'd10: v = 16'h090A;
			5'd11: v = 16'h0A42;
			5'd12: v = 16'h0C3B;
			5'd13: v = 16'h0EC2;
			5'd14: v = 16'h1137;
			5'd15: v = 16'h13A7;
			5'd16: v = 16'h1750;
			5'd17: v = 16'h1BF9;
			5'd18: v = 16'h20DF;
			5'd19: v = 16'h2596;
			5'd20: v = 16'h2C9D;
			5'd21: v = 16'h3579;
			5'd22: v = 16'h3E55;
			5'd23: v = 16'h4768;
			5'd24: v = 16'h54FF;
			5'd25: v = 16'h6624;
			5'd26: v = 16'h773B;
			5'd27: v = 16'h883F;
			5'd28: v = 16'hA1DA;
			5'd29: v = 16'hC0FC;
			5'd30: v = 16'hE094;
			default: v = 16'hFFFF;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/psg_sound_generator.sv */
// ----------------------------------------------------------------------------
// psg_sound_generator
// Three-channel programmable sound generator with tone, noise and envelope.
// ----------------------------------------------------------------------------
// Usage: each input item is a register write, a register read or one
// generator tick, chosen by req_type. Writes give no result; a read returns
// the register byte in read_data with all levels zero; a tick advances the
// tone, noise and envelope dividers and returns the three channel levels
// with read_data zero. Request type 3 is dropped without a result.
// Configuration (oversample, level table select, mute_mask) goes through the
// cfg port, which is always ready; write it only while no item is in flight.
// Timing: an item passes an input register and then a result register,
// which drives out_valid and the result data. One item is taken every
// cycle while in_stall stays low.
// When the receiver stalls, the result register holds; the input register
// keeps taking one more item, then in_stall rises until the result drains.
// Reset puts the valid flags and generator state at power-on values at once:
// registers 14 and 15 read 0xff, the noise shift register holds 1, the
// envelope level is 31 and decaying.
// ----------------------------------------------------------------------------
module psg_sound_generator (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  reg_index,
	input  logic [7:0]  write_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [15:0] level_a,
	output logic [15:0] level_b,
	output logic [15:0] level_c,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import psg_pkg::*;

	logic [OVS_W-1:0] oversample_q;
	logic             table_sel_q;
	logic [2:0]       mute_q;
	logic [7:0]       regs_q [16];

	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [3:0] reg_index_s1;
	logic [7:0] write_data_s1;

	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [15:0] level_a_q;
	logic [15:0] level_b_q;
	logic [15:0] level_c_q;

	logic             advance;
	logic             do_tick;
	logic             do_write;
	logic             do_read;
	logic [OVS_W-1:0] ovs;
	psg_env_ctl_t     env_ctl;
	psg_mix_ctl_t     mix_ctl;
	logic             tone_flag [3];
	logic             noise_flag;
	logic [4:0]       env_level;
	logic [4:0]       amp [3];
	logic [15:0]      level [3];

	// handshake
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign do_tick   = advance && (req_type_s1 == REQ_TICK);
	assign do_write  = advance && (req_type_s1 == REQ_WRITE);
	assign do_read   = advance && (req_type_s1 == REQ_READ);
	assign ovs       = (oversample_q > OVS_MAX) ? OVS_MAX : oversample_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oversample_q <= 5'd1;
			table_sel_q  <= 1'b0;
			mute_q       <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OVERSAMPLE: oversample_q <= cfg_data[OVS_W-1:0];
				CFG_TABLE_SEL:  table_sel_q  <= cfg_data[0];
				CFG_MUTE_MASK:  mute_q       <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_type_s1   <= req_type;
			reg_index_s1  <= reg_index;
			write_data_s1 <= write_data;
		end
	end

	// sound register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= (4'(i) >= REG_PORT_A) ? 8'hff : 8'h00;
			end
		end else if (do_write) begin
			regs_q[reg_index_s1] <= write_data_s1;
		end
	end

	// generator units
	for (genvar c = 0; c < 3; c++) begin : g_tone
		psg_tone u_tone (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (do_tick),
			.period    ({regs_q[2 * c + 1][3:0], regs_q[2 * c]}),
			.ovs       (ovs),
			.flag_next (tone_flag[c])
		);
		assign amp[c] = regs_q[REG_AMP_A + 4'(c)][4:0];
	end

	psg_noise u_noise (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (do_tick),
		.period    (regs_q[REG_NOISE_PER][4:0]),
		.ovs       (ovs),
		.flag_next (noise_flag)
	);

	always_comb begin
		env_ctl.tick    = do_tick;
		env_ctl.restart = do_write && (reg_index_s1 == REG_SHAPE);
		env_ctl.shape   = write_data_s1[3:0];
		mix_ctl.table_sel = table_sel_q;
		mix_ctl.mute      = mute_q;
		mix_ctl.mixer     = regs_q[REG_MIXER][5:0];
	end

	psg_env u_env (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (env_ctl),
		.period     ({regs_q[REG_ENV_COARSE], regs_q[REG_ENV_FINE]}),
		.ovs        (ovs),
		.level_next (env_level)
	);

	psg_mixer u_mixer (
		.tone_flag  (tone_flag),
		.noise_flag (noise_flag),
		.amp        (amp),
		.env_level  (env_level),
		.ctl        (mix_ctl),
		.level      (level)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= do_read || do_tick;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			read_data_q <= regs_q[reg_index_s1];
			level_a_q   <= 16'd0;
			level_b_q   <= 16'd0;
			level_c_q   <= 16'd0;
		end else if (do_tick) begin
			read_data_q <= 8'd0;
			level_a_q   <= level[0];
			level_b_q   <= level[1];
			level_c_q   <= level[2];
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign level_a   = level_a_q;
	assign level_b   = level_b_q;
	assign level_c   = level_c_q;

	// a read result carries no levels
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && read_data_q != 8'd0) |->
			(level_a_q == 16'd0 && level_b_q == 16'd0 && level_c_q == 16'd0))
		else $error("read result with nonzero levels");

	// a read returns the register as it stood
	assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> (out_valid_q && read_data_q == $past(regs_q[reg_index_s1])))
		else $error("read result mismatch");

	// a write leaves the result register empty
	assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> !out_valid_q)
		else $error("write produced a result");

	// the input side stalls only behind a held item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("stall without a blocked item");

endmodule

/* rtl/core/psg_tone.sv */
// ----------------------------------------------------------------------------
// psg_tone
// One tone divider: counts ticks against period times oversample and
// toggles its square-wave flag at each wrap.
// ----------------------------------------------------------------------------
module psg_tone (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tick,
	input  logic [11:0]              period,
	input  logic [psg_pkg::OVS_W-1:0] ovs,
	output logic                     flag_next
);
	logic [15:0] cnt_q;
	logic        flag_q;
	logic [16:0] per;
	logic [15:0] inc;
	logic [15:0] cnt_d;
	logic        wrap;

	// scaled period and wrap detect
	always_comb begin
		per   = {5'd0, period} * {12'd0, ovs};
		inc   = cnt_q + 16'd1;
		wrap  = {1'b0, inc} >= per;
		cnt_d = inc;
		if (wrap) begin
			cnt_d = (per == 17'd0) ? 16'd0 : inc - per[15:0];
		end
		flag_next = tick ? (flag_q ^ wrap) : flag_q;
	end

	// counter and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			flag_q <= 1'b0;
		end else if (tick) begin
			cnt_q  <= cnt_d;
			flag_q <= flag_next;
		end
	end

endmodule

/* rtl/core/psg_noise.sv */
// ----------------------------------------------------------------------------
// psg_noise
// Noise divider clocking a 17-bit shift register that drives the noise flag.
// ----------------------------------------------------------------------------
module psg_noise (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tick,
	input  logic [4:0]               period,
	input  logic [psg_pkg::OVS_W-1:0] ovs,
	output logic                     flag_next
);
	import psg_pkg::*;

	logic [9:0]  cnt_q;
	logic [16:0] lfsr_q;
	logic        flag_q;
	logic [10:0] per;
	logic [9:0]  inc;
	logic        fire;
	logic [17:0] fb;
	logic [16:0] lfsr_d;

	// divider and shift register step
	always_comb begin
		per    = {5'd0, period, 1'b0} * {6'd0, ovs};
		inc    = cnt_q + 10'd1;
		fire   = {1'b0, inc} >= per;
		fb     = {1'b0, lfsr_q} ^ (lfsr_q[0] ? NOISE_TAPS : 18'd0);
		lfsr_d = fb[17:1];
		flag_next = flag_q;
		if (tick && fire) begin
			flag_next = flag_q ^ (lfsr_q[0] ^ lfsr_q[1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			lfsr_q <= 17'd1;
			flag_q <= 1'b1;
		end else if (tick) begin
			cnt_q  <= fire ? 10'd0 : inc;
			flag_q <= flag_next;
			if (fire) begin
				lfsr_q <= lfsr_d;
			end
		end
	end

endmodule

/* rtl/core/psg_env.sv */
// ----------------------------------------------------------------------------
// psg_env
// Envelope generator: period divider and a 32-step level sequencer whose
// phase follows the selected shape.
// ----------------------------------------------------------------------------
module psg_env (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psg_pkg::psg_env_ctl_t    ctl,
	input  logic [15:0]              period,
	input  logic [psg_pkg::OVS_W-1:0] ovs,
	output logic [4:0]               level_next
);
	import psg_pkg::*;

	typedef enum logic [8:0] {
		PH_DECAY     = 9'b000000001,
		PH_ATTACK    = 9'b000000010,
		PH_SAW_DN    = 9'b000000100,
		PH_TRI_DN    = 9'b000001000,
		PH_DECAY_HI  = 9'b000010000,
		PH_SAW_UP    = 9'b000100000,
		PH_ATTACK_HI = 9'b001000000,
		PH_TRI_UP    = 9'b010000000,
		PH_HOLD      = 9'b100000000
	} env_phase_t;

	logic [19:0] cnt_q;
	logic [4:0]  level_q;
	env_phase_t  phase_q;
	logic [20:0] per;
	logic [19:0] inc;
	logic        fire;
	logic [4:0]  lvl_step;
	env_phase_t  ph_step;
	logic [4:0]  lvl_start;
	env_phase_t  ph_start;

	// divider
	always_comb begin
		per  = {5'd0, period} * {16'd0, ovs};
		inc  = cnt_q + 20'd1;
		fire = {1'b0, inc} >= per;
	end

	// one sequencer step
	always_comb begin
		lvl_step = level_q;
		ph_step  = phase_q;
		unique case (phase_q)
			PH_DECAY: begin
				lvl_step = level_q - 5'd1;
				if (level_q == 5'd1) ph_step = PH_HOLD;
			end
			PH_ATTACK: begin
				lvl_step = level_q + 5'd1;
				if (level_q == 5'd31) ph_step = PH_HOLD;
			end
			PH_SAW_DN: lvl_step = level_q - 5'd1;
			PH_TRI_DN: begin
				if (level_q == 5'd0) ph_step = PH_TRI_UP;
				else lvl_step = level_q - 5'd1;
			end
			PH_DECAY_HI: begin
				lvl_step = level_q - 5'd1;
				if (level_q == 5'd0) ph_step = PH_HOLD;
			end
			PH_SAW_UP: lvl_step = level_q + 5'd1;
			PH_ATTACK_HI: begin
				lvl_step = level_q + 5'd1;
				if (level_q == 5'd30) ph_step = PH_HOLD;
			end
			PH_TRI_UP: begin
				if (level_q == 5'd31) ph_step = PH_TRI_DN;
				else lvl_step = level_q + 5'd1;
			end
			default: begin
				lvl_step = level_q;
				ph_step  = phase_q;
			end
		endcase
	end

	// start point of a shape; shapes below 8 fold to plain decay or attack
	always_comb begin
		lvl_start = 5'd31;
		ph_start  = PH_DECAY;
		unique case (ctl.shape)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd9: begin
				lvl_start = 5'd31;
				ph_start  = PH_DECAY;
			end
			4'd8: begin
				lvl_start = 5'd31;
				ph_start  = PH_SAW_DN;
			end
			4'd10: begin
				lvl_start = 5'd31;
				ph_start  = PH_TRI_DN;
			end
			4'd11: begin
				lvl_start = 5'd31;
				ph_start  = PH_DECAY_HI;
			end
			4'd12: begin
				lvl_start = 5'd0;
				ph_start  = PH_SAW_UP;
			end
			4'd13: begin
				lvl_start = 5'd0;
				ph_start  = PH_ATTACK_HI;
			end
			4'd14: begin
				lvl_start = 5'd0;
				ph_start  = PH_TRI_UP;
			end
			default: begin
				lvl_start = 5'd0;
				ph_start  = PH_ATTACK;
			end
		endcase
	end

	assign level_next = ctl.restart ? lvl_start :
		((ctl.tick && fire) ? lvl_step : level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			level_q <= 5'd31;
			phase_q <= PH_DECAY;
		end else if (ctl.restart) begin
			cnt_q   <= '0;
			level_q <= lvl_start;
			phase_q <= ph_start;
		end else if (ctl.tick) begin
			cnt_q <= fire ? 20'd0 : inc;
			if (fire) begin
				level_q <= lvl_step;
				phase_q <= ph_step;
			end
		end
	end

	// a restart loads a level of zero or full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.restart |=> (level_q == 5'd0 || level_q == 5'd31))
		else $error("envelope restart level out of set");

	// the hold phase never moves the level
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HOLD && !ctl.restart) |=> $stable(level_q))
		else $error("envelope level moved while holding");

	// after a fire the divider starts over
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.tick && !ctl.restart && fire) |=> cnt_q == 20'd0)
		else $error("envelope divider did not clear");

endmodule

/* rtl/core/psg_mixer.sv */
// ----------------------------------------------------------------------------
// psg_mixer
// Channel gates and amplitude lookup for the three channels.
// ----------------------------------------------------------------------------
module psg_mixer (
	input  logic                  tone_flag [3],
	input  logic                  noise_flag,
	input  logic [4:0]            amp [3],
	input  logic [4:0]            env_level,
	input  psg_pkg::psg_mix_ctl_t ctl,
	output logic [15:0]           level [3]
);
	import psg_pkg::*;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic       gate;
		logic [4:0] idx;

		// tone and noise gate with mixer disables, then table lookup
		always_comb begin
			gate = (tone_flag[c] | ctl.mixer[c]) & (noise_flag | ctl.mixer[3 + c]) &
				~ctl.mute[c];
			idx = amp[c][4] ? env_level : {amp[c][3:0], 1'b0};
			if (!gate) begin
				level[c] = 16'd0;
			end else if (ctl.table_sel) begin
				level[c] = lvl_ym(idx);
			end else begin
				level[c] = lvl_ay(idx[4:1]);
			end
		end
	end

endmodule
